FILE: rtl/detection_row_decoder_assert.svh
// Assertion macros shared by the checker files of the detection row decoder.
`ifndef DETECTION_ROW_DECODER_ASSERT_SVH
`define DETECTION_ROW_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/drd_pkg.sv
// Shared types and constants of the detection row decoder.
package drd_pkg;

  localparam int unsigned MaxClasses             = 64;
  localparam int unsigned FeatureFracBitsDefault = 16;
  localparam logic [6:0]  NoClass                = 7'd127;
  localparam logic [16:0] ConfOne                = 17'd65536;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgHasObjectness       = 3'd0,
    CfgClassCount          = 3'd1,
    CfgConfidenceThreshold = 3'd2,
    CfgInverseScale        = 3'd3,
    CfgPadOffsets          = 3'd4,
    CfgImageSize           = 3'd5,
    CfgMinBoxSize          = 3'd6,
    CfgAllowedClassMask    = 3'd7
  } cfg_index_e;

  typedef struct packed {
    cfg_index_e  index;
    logic [63:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic signed [31:0] feature_value;
    logic               feature_finite;
  } feature_t;

  typedef struct packed {
    logic [5:0]  class_index;
    logic [16:0] confidence;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
  } result_t;

endpackage

FILE: rtl/drd_stream_if.sv
// Valid/ready channel carrying one payload per transfer.
interface drd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/detection_row_decoder.sv
// Detection row decoder: streams detector features, emits one box per kept row.
//
//  channel    dir  payload                                   transfer when
//  cfg_i      in   index, value (register write)             valid & ready (ready always 1)
//  feat_i     in   feature_value, feature_finite             valid & ready
//  result_o   out  class, confidence, left, top, w, h        valid & ready
//
//  One feature is taken every cycle unless a stalled result backs up the pipeline;
//  the running argmax needs one compare per feature. A row's result reaches the output
//  register via snapshot, multiply, scale/clip, size check; dropped rows produce nothing.
//  Reset clears the configuration to its defaults and the row state; no clearing pass.
//  A stalled result only blocks the input once all four pipeline stages are full.
module detection_row_decoder #(
  parameter int unsigned FEATURE_FRAC_BITS = drd_pkg::FeatureFracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  drd_stream_if.sink   cfg_i,
  drd_stream_if.sink   feat_i,
  drd_stream_if.source result_o
);
  import drd_pkg::*;

  localparam int unsigned F   = FEATURE_FRAC_BITS;
  // corner numerator width: |2cx| + |w| + pad fits with margin
  localparam int unsigned NW  = (F + 19 > 35) ? F + 19 : 35;
  localparam int unsigned PW  = NW + 13;
  localparam int unsigned TW  = PW + 1;
  localparam int unsigned DSH = F + 5;
  localparam int unsigned CSH = 2 * F - 16;
  localparam logic signed [31:0] OneFeature = 32'sd1 <<< F;

  // ---------------- configuration registers ----------------
  logic        has_obj_q;
  logic [6:0]  num_classes_q;
  logic [16:0] conf_thr_q;
  logic [23:0] inv_scale_q;
  logic [31:0] pad_q;
  logic [31:0] img_q;
  logic [15:0] min_box_q;
  logic [63:0] mask_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_obj_q     <= 1'b0;
      num_classes_q <= 7'd1;
      conf_thr_q    <= 17'd16384;
      inv_scale_q   <= 24'd65536;
      pad_q         <= '0;
      img_q         <= '0;
      min_box_q     <= '0;
      mask_q        <= '1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.data.index)
        CfgHasObjectness:       has_obj_q     <= cfg_i.data.value[0];
        CfgClassCount:          num_classes_q <= cfg_i.data.value[6:0];
        CfgConfidenceThreshold: conf_thr_q    <= cfg_i.data.value[16:0];
        CfgInverseScale:        inv_scale_q   <= cfg_i.data.value[23:0];
        CfgPadOffsets:          pad_q         <= cfg_i.data.value[31:0];
        CfgImageSize:           img_q         <= cfg_i.data.value[31:0];
        CfgMinBoxSize:          min_box_q     <= cfg_i.data.value[15:0];
        CfgAllowedClassMask:    mask_q        <= cfg_i.data.value;
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4;

  assign ld4 = !v4_q || result_o.ready;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign feat_i.ready = ld1;

  logic in_xfer;
  assign in_xfer = feat_i.valid && feat_i.ready;

  // ---------------- row accumulation ----------------
  logic [6:0]         pos_q;
  logic signed [31:0] cx_q, cy_q, rw_q, rh_q, obj_q, best_score_q;
  logic [6:0]         lead_class_q;
  logic               invalid_q;

  logic [6:0]         cc_eff;
  logic [6:0]         first_score;
  logic [6:0]         row_len;
  logic [7:0]         pos_inc;
  logic               row_end;
  logic [6:0]         score_idx;
  logic               score_slot;
  logic signed [31:0] v;
  logic               take_score;
  logic signed [31:0] bs_m;
  logic [6:0]         bc_m;
  logic               inv_m;
  logic signed [31:0] obj_eff;
  logic               keep1;

  always_comb begin
    if (num_classes_q == 7'd0) begin
      cc_eff = 7'd1;
    end else if (num_classes_q > 7'(MaxClasses)) begin
      cc_eff = 7'(MaxClasses);
    end else begin
      cc_eff = num_classes_q;
    end
    first_score = 7'd4 + {6'd0, has_obj_q};
    row_len     = first_score + cc_eff;
    pos_inc     = {1'b0, pos_q} + 8'd1;
    row_end     = pos_inc >= {1'b0, row_len};
    score_idx   = pos_q - first_score;
    score_slot  = (pos_q >= first_score) && (score_idx < cc_eff);
    v           = feat_i.data.feature_value;
    take_score  = score_slot && (v > best_score_q);
    bs_m        = take_score ? v : best_score_q;
    bc_m        = take_score ? score_idx : lead_class_q;
    inv_m       = invalid_q || !feat_i.data.feature_finite;
    obj_eff     = has_obj_q ? obj_q : OneFeature;
    keep1       = !inv_m && (obj_eff > 32'sd0) && (bc_m != NoClass);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      rw_q         <= '0;
      rh_q         <= '0;
      obj_q        <= OneFeature;
      best_score_q <= '0;
      lead_class_q <= NoClass;
      invalid_q    <= 1'b0;
    end else if (in_xfer) begin
      if (row_end) begin
        pos_q        <= '0;
        cx_q         <= '0;
        cy_q         <= '0;
        rw_q         <= '0;
        rh_q         <= '0;
        obj_q        <= OneFeature;
        best_score_q <= '0;
        lead_class_q <= NoClass;
        invalid_q    <= 1'b0;
      end else begin
        pos_q     <= pos_inc[6:0];
        invalid_q <= inv_m;
        priority if (pos_q == 7'd0) begin
          cx_q <= v;
        end else if (pos_q == 7'd1) begin
          cy_q <= v;
        end else if (pos_q == 7'd2) begin
          rw_q <= v;
        end else if (pos_q == 7'd3) begin
          rh_q <= v;
        end else if (pos_q < first_score) begin
          obj_q <= v;
        end else begin
          // class score: only a strictly higher one replaces the leader
          if (take_score) begin
            best_score_q <= v;
            lead_class_q <= score_idx;
          end
        end
      end
    end
  end

  // ---------------- stage 1: row snapshot, corner numerators ----------------
  // index 0: left, 1: top, 2: right (negated), 3: bottom (negated)
  logic signed [NW-1:0] n_d [4];
  logic signed [NW-1:0] n1_q [4];
  logic [30:0]          obj1_q, bs1_q;
  logic [6:0]           bc1_q;

  logic signed [NW-1:0] px_ext, py_ext;
  logic signed [NW-1:0] cx2, cy2, rw_ext, rh_ext;

  always_comb begin
    px_ext = $signed(NW'({pad_q[15:0], {(F + 1){1'b0}}}));
    py_ext = $signed(NW'({pad_q[31:16], {(F + 1){1'b0}}}));
    cx2    = NW'(cx_q) <<< 1;
    cy2    = NW'(cy_q) <<< 1;
    rw_ext = NW'(rw_q);
    rh_ext = NW'(rh_q);
    n_d[0] = cx2 - rw_ext - px_ext;
    n_d[1] = cy2 - rh_ext - py_ext;
    n_d[2] = px_ext - cx2 - rw_ext;
    n_d[3] = py_ext - cy2 - rh_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ld1) begin
      v1_q <= in_xfer && row_end && keep1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      n1_q   <= n_d;
      obj1_q <= obj_eff[30:0];
      bs1_q  <= bs_m[30:0];
      bc1_q  <= bc_m;
    end
  end

  // ---------------- stage 2: products ----------------
  logic [23:0]          inv_eff;
  logic signed [PW-1:0] q2_q [4];
  logic signed [PW-1:0] r2_q [4];
  logic [61:0]          conf2_q;
  logic [6:0]           bc2_q;

  assign inv_eff = (inv_scale_q == 24'd0) ? 24'd1 : inv_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ld2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      for (int k = 0; k < 4; k++) begin
        q2_q[k] <= $signed(PW'(n1_q[k])) * $signed(PW'({1'b0, inv_eff[23:12]}));
        r2_q[k] <= $signed(PW'(n1_q[k])) * $signed(PW'({1'b0, inv_eff[11:0]}));
      end
      conf2_q <= 62'(obj1_q) * 62'(bs1_q);
      bc2_q   <= bc1_q;
    end
  end

  // ---------------- stage 3: scale, clip, confidence checks ----------------
  function automatic logic [15:0] clamp_px(input logic signed [TW-1:0] val,
                                           input logic [15:0] hi);
    logic [15:0] res;
    priority if (val < 0) begin
      res = 16'd0;
    end else if (val > $signed(TW'({1'b0, hi}))) begin
      res = hi;
    end else begin
      res = val[15:0];
    end
    return res;
  endfunction

  logic [61:0]          conf_sh;
  logic [16:0]          conf_sat;
  logic                 keep3;
  logic signed [TW-1:0] t_d [4];
  logic signed [TW-1:0] f_d [4];
  logic [15:0]          c_d [4];
  logic [15:0]          c3_q [4];
  logic [16:0]          conf3_q;
  logic [5:0]           bc3_q;

  always_comb begin
    conf_sh  = conf2_q >> CSH;
    conf_sat = (conf_sh > 62'(ConfOne)) ? ConfOne : conf_sh[16:0];
    keep3    = (conf_sat >= conf_thr_q) && mask_q[bc2_q[5:0]] &&
               (img_q[15:0] != 16'd0) && (img_q[31:16] != 16'd0);
    for (int k = 0; k < 4; k++) begin
      t_d[k] = TW'(q2_q[k]) + TW'(r2_q[k] >>> 12);
      f_d[k] = t_d[k] >>> DSH;
      // right and bottom use ceil = -floor(-x)
      c_d[k] = clamp_px((k >= 2) ? -f_d[k] : f_d[k],
                        ((k % 2) == 0) ? img_q[15:0] : img_q[31:16]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ld3) begin
      v3_q <= v2_q && keep3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      c3_q    <= c_d;
      conf3_q <= conf_sat;
      bc3_q   <= bc2_q[5:0];
    end
  end

  // ---------------- stage 4: box size, result register ----------------
  logic [15:0] bw, bh;
  logic        keep4;
  result_t     res_q;

  always_comb begin
    bw    = (c3_q[2] > c3_q[0]) ? c3_q[2] - c3_q[0] : 16'd0;
    bh    = (c3_q[3] > c3_q[1]) ? c3_q[3] - c3_q[1] : 16'd0;
    keep4 = (bw >= min_box_q) && (bh >= min_box_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ld4) begin
      v4_q <= v3_q && keep4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      res_q.class_index <= bc3_q;
      res_q.confidence  <= conf3_q;
      res_q.box_left    <= c3_q[0];
      res_q.box_top     <= c3_q[1];
      res_q.box_width   <= bw;
      res_q.box_height  <= bh;
    end
  end

  assign result_o.valid = v4_q;
  assign result_o.data  = res_q;

endmodule

FILE: rtl/drd_checker.sv
// Port-level checks of the detection row decoder, bound to the top level.
`include "detection_row_decoder_assert.svh"

module drd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              feat_ready_i,
  input logic              result_valid_i,
  input logic              result_ready_i,
  input drd_pkg::result_t  result_data_i
);
  import drd_pkg::*;

  // a pending result stays offered
  `DRD_ASSERT_NXT(a_result_hold, clk_i, rst_ni, result_valid_i && !result_ready_i, result_valid_i, "result dropped while stalled")

  // a stalled result keeps its payload
  `DRD_ASSERT_NXT(a_result_stable, clk_i, rst_ni, result_valid_i && !result_ready_i, $stable(result_data_i), "result changed while stalled")

  // the input only backs up behind a stalled result
  `DRD_ASSERT_IMP(a_stall_source, clk_i, rst_ni, !feat_ready_i, result_valid_i && !result_ready_i, "input stalled without output stall")

  // confidence is saturated at one
  `DRD_ASSERT_IMP(a_conf_range, clk_i, rst_ni, result_valid_i, result_data_i.confidence <= ConfOne, "confidence above one")

endmodule

bind detection_row_decoder drd_checker u_drd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .feat_ready_i   (feat_i.ready),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .result_data_i  (result_o.data)
);

FILE: test/testbench.sv
// Testbench for the detection row decoder: row box prediction checked against the output.
`timescale 1ns / 1ps

module testbench;
  import drd_pkg::*;

  localparam int unsigned FracBits    = FeatureFracBitsDefault;
  localparam int unsigned IdlePercent = 17;
  localparam int unsigned StallCycles = 100;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 1050;

  // Predicts the boxes of each row and checks them in order of arrival
  class box_scoreboard;
    logic        has_obj;
    logic [6:0]  num_classes;
    logic [16:0] conf_threshold;
    logic [23:0] inv_scale;
    logic [31:0] pad_offsets;
    logic [31:0] image_size;
    logic [15:0] min_box;
    logic [63:0] class_mask;

    int unsigned position;
    longint      ctr_x, ctr_y, raw_w, raw_h, objectness, best_score;
    logic [6:0]  lead_class;
    bit          row_bad;

    result_t     expected_boxes[$];
    int unsigned mismatches;
    int unsigned boxes_seen;

    function new();
      has_obj        = 1'b0;
      num_classes    = 7'd1;
      conf_threshold = 17'd16384;
      inv_scale      = 24'd65536;
      pad_offsets    = '0;
      image_size     = '0;
      min_box        = '0;
      class_mask     = '1;
      mismatches     = 0;
      boxes_seen     = 0;
      clear_row();
    endfunction

    function void clear_row();
      position   = 0;
      ctr_x      = 0;
      ctr_y      = 0;
      raw_w      = 0;
      raw_h      = 0;
      objectness = 64'sd1 << FracBits;
      best_score = 0;
      lead_class = NoClass;
      row_bad    = 1'b0;
    endfunction

    // floor(n * inverse_scale / 2^(frac+17)), exact in a wide product
    function longint scaled_floor(longint n);
      logic signed [95:0] wide_n;
      logic signed [95:0] wide_inv;
      logic signed [95:0] prod;
      wide_n   = n;
      wide_inv = $signed({72'd0, (inv_scale == 24'd0) ? 24'd1 : inv_scale});
      prod     = wide_n * wide_inv;
      return longint'(prod >>> (FracBits + 17));
    endfunction

    function longint clip(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_register(cfg_index_e idx, logic [63:0] v);
      case (idx)
        CfgHasObjectness:       has_obj        = v[0];
        CfgClassCount:          num_classes    = v[6:0];
        CfgConfidenceThreshold: conf_threshold = v[16:0];
        CfgInverseScale:        inv_scale      = v[23:0];
        CfgPadOffsets:          pad_offsets    = v[31:0];
        CfgImageSize:           image_size     = v[31:0];
        CfgMinBoxSize:          min_box        = v[15:0];
        CfgAllowedClassMask:    class_mask     = v;
        default: ;
      endcase
    endfunction

    // Features per row under the current registers, class count clamped
    function int unsigned row_length();
      int unsigned cc;
      cc = num_classes;
      if (cc == 0) cc = 1;
      if (cc > MaxClasses) cc = MaxClasses;
      return 4 + has_obj + cc;
    endfunction

    // One accepted feature: update the row and predict a box at row end
    function void note_feature(feature_t f);
      int unsigned first_score, len, cc;
      longint      v, obj, conf, px, py, img_w, img_h;
      longint      x1, y1, x2, y2, bw, bh;
      result_t     box;
      first_score = 4 + has_obj;
      len         = row_length();
      cc          = len - first_score;
      v           = $signed(f.feature_value);
      if (!f.feature_finite) row_bad = 1'b1;

      if (position == 0) ctr_x = v;
      else if (position == 1) ctr_y = v;
      else if (position == 2) raw_w = v;
      else if (position == 3) raw_h = v;
      else if (position < first_score) objectness = v;
      else if (position - first_score < cc && v > best_score) begin
        // strictly higher only, so the first of equal scores wins
        best_score = v;
        lead_class = 7'(position - first_score);
      end

      if (position + 1 < len) begin
        position = (position + 1) & 32'h7F;
        return;
      end

      obj   = has_obj ? objectness : (64'sd1 << FracBits);
      img_w = image_size[15:0];
      img_h = image_size[31:16];
      px    = pad_offsets[15:0];
      py    = pad_offsets[31:16];
      px    = px << (FracBits + 1);
      py    = py << (FracBits + 1);
      if (!row_bad && obj > 0 && lead_class != NoClass) begin
        conf = (obj * best_score) >>> (2 * FracBits - 16);
        if (conf > 65536) conf = 65536;
        if (conf >= conf_threshold && class_mask[lead_class[5:0]] &&
            img_w != 0 && img_h != 0) begin
          // corners in doubled units: floor the near edge, ceil the far edge
          x1 = clip(scaled_floor(2 * ctr_x - raw_w - px), img_w);
          y1 = clip(scaled_floor(2 * ctr_y - raw_h - py), img_h);
          x2 = clip(-scaled_floor(-(2 * ctr_x + raw_w - px)), img_w);
          y2 = clip(-scaled_floor(-(2 * ctr_y + raw_h - py)), img_h);
          bw = (x2 > x1) ? x2 - x1 : 0;
          bh = (y2 > y1) ? y2 - y1 : 0;
          if (bw >= min_box && bh >= min_box) begin
            box.class_index = lead_class[5:0];
            box.confidence  = conf[16:0];
            box.box_left    = x1[15:0];
            box.box_top     = y1[15:0];
            box.box_width   = bw[15:0];
            box.box_height  = bh[15:0];
            expected_boxes  = {expected_boxes, box};
          end
        end
      end
      clear_row();
    endfunction

    // One accepted box against the oldest prediction
    function void check_box(result_t got);
      result_t want;
      boxes_seen++;
      if (expected_boxes.size() == 0) begin
        $error("unexpected box: class_index %0d confidence %0d",
               got.class_index, got.confidence);
        mismatches++;
        return;
      end
      want = expected_boxes.pop_front();
      if (got.class_index !== want.class_index) begin
        $error("class_index expected %0d got %0d", want.class_index, got.class_index);
        mismatches++;
      end
      if (got.confidence !== want.confidence) begin
        $error("confidence expected %0d got %0d", want.confidence, got.confidence);
        mismatches++;
      end
      if (got.box_left !== want.box_left) begin
        $error("box_left expected %0d got %0d", want.box_left, got.box_left);
        mismatches++;
      end
      if (got.box_top !== want.box_top) begin
        $error("box_top expected %0d got %0d", want.box_top, got.box_top);
        mismatches++;
      end
      if (got.box_width !== want.box_width) begin
        $error("box_width expected %0d got %0d", want.box_width, got.box_width);
        mismatches++;
      end
      if (got.box_height !== want.box_height) begin
        $error("box_height expected %0d got %0d", want.box_height, got.box_height);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  drd_stream_if #(.payload_t(cfg_write_t)) cfg_if ();
  drd_stream_if #(.payload_t(feature_t))   feat_if ();
  drd_stream_if #(.payload_t(result_t))    box_if ();

  detection_row_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .feat_i   (feat_if),
    .result_o (box_if)
  );

  box_scoreboard boxes = new();
  bit            quiet;
  bit            stall_req;
  int unsigned   items_sent;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin : box_sink
    int unsigned hold_left;
    hold_left    = 0;
    box_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = StallCycles;
      end
      if (hold_left > 0) begin
        box_if.ready = 1'b0;
        hold_left--;
      end else begin
        box_if.ready = quiet || ($urandom_range(99) >= IdlePercent);
      end
      @(posedge clk_i);
      if (rst_ni && box_if.valid === 1'b1 && box_if.ready) boxes.check_box(box_if.data);
    end
  end

  function automatic feature_t feat(logic [31:0] v, logic fin);
    feature_t f;
    f.feature_value  = v;
    f.feature_finite = fin;
    return f;
  endfunction

  // Offer one feature and hold it until the transfer
  task automatic send_feature(feature_t f);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      feat_if.valid = 1'b0;
      feat_if.data  = feat($urandom, 1'($urandom_range(1)));
      @(negedge clk_i);
    end
    feat_if.data  = f;
    feat_if.valid = 1'b1;
    do @(posedge clk_i); while (feat_if.ready !== 1'b1);
    boxes.note_feature(f);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering until every predicted box is out and the pipeline is empty
  task automatic wait_for_boxes();
    feat_if.valid = 1'b0;
    while (boxes.expected_boxes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [63:0] v);
    wait_for_boxes();
    cfg_if.data.index = idx;
    cfg_if.data.value = v;
    cfg_if.valid      = 1'b1;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    boxes.write_register(idx, v);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Half the time, set the bits above a register's width
  function automatic logic [63:0] with_junk(logic [63:0] v, int unsigned width);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(1)) return v | (junk << width);
    return v;
  endfunction

  task automatic apply_setting(logic has, logic [6:0] cc, logic [16:0] thr, logic [23:0] inv,
                               logic [31:0] pad, logic [31:0] img, logic [15:0] minb,
                               logic [63:0] mask);
    write_reg(CfgHasObjectness,       with_junk(64'(has), 1));
    write_reg(CfgClassCount,          with_junk(64'(cc), 7));
    write_reg(CfgConfidenceThreshold, with_junk(64'(thr), 17));
    write_reg(CfgInverseScale,        with_junk(64'(inv), 24));
    write_reg(CfgPadOffsets,          with_junk(64'(pad), 32));
    write_reg(CfgImageSize,           with_junk(64'(img), 32));
    write_reg(CfgMinBoxSize,          with_junk(64'(minb), 16));
    write_reg(CfgAllowedClassMask,    mask);
  endtask

  task automatic send_values(logic [31:0] vals[$], int bad_at);
    foreach (vals[i]) send_feature(feat(vals[i], i != bad_at));
  endtask

  // Random setting; each register lands on an extreme about a quarter of the time
  task automatic random_setting();
    logic        has;
    logic [6:0]  cc;
    logic [16:0] thr;
    logic [23:0] inv;
    logic [31:0] pad, img;
    logic [15:0] minb;
    logic [63:0] mask;
    has = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: cc = 7'd0;
        1: cc = 7'd64;
        2: cc = 7'd65;
        default: cc = 7'd127;
      endcase
    end else cc = 7'($urandom_range(1, 6));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: thr = 17'd0;
        1: thr = 17'd65536;
        2: thr = 17'd65537;
        default: thr = 17'h1FFFF;
      endcase
    end else thr = 17'($urandom_range(0, 40000));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: inv = 24'd0;
        1: inv = 24'd1;
        default: inv = 24'hFFFFFF;
      endcase
    end else inv = 24'($urandom_range(40000, 100000));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: pad = 32'h0;
        1: pad = 32'hFFFF_FFFF;
        default: pad = $urandom;
      endcase
    end else pad = {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))};
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: img = 32'h0;
        1: img = 32'hFFFF_FFFF;
        2: img = 32'h0000_FFFF;
        default: img = 32'hFFFF_0000;
      endcase
    end else img = {16'($urandom_range(100, 1000)), 16'($urandom_range(100, 1000))};
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: minb = 16'hFFFF;
        1: minb = 16'h0;
        default: minb = 16'($urandom_range(0, 65535));
      endcase
    end else minb = 16'($urandom_range(0, 10));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: mask = 64'h0;
        1: mask = {$urandom, $urandom};
        default: mask = '1;
      endcase
    end else mask = '1;
    apply_setting(has, cc, thr, inv, pad, img, minb, mask);
  endtask

  // One row: plausible boxes and scores, or all-random noise
  task automatic send_random_row(bit noisy);
    int unsigned len, first_score, img_w, img_h, coord, pick;
    logic [31:0] v, last_score;
    logic        fin;
    len         = boxes.row_length();
    first_score = 4 + boxes.has_obj;
    img_w       = boxes.image_size[15:0];
    img_h       = boxes.image_size[31:16];
    if (img_w == 0) img_w = 640;
    if (img_h == 0) img_h = 480;
    last_score  = '0;
    for (int unsigned p = 0; p < len; p++) begin
      fin  = noisy ? ($urandom_range(99) < 80) : ($urandom_range(99) < 98);
      pick = $urandom_range(99);
      if (noisy) begin
        v = $urandom;
      end else if (p < 2) begin
        coord = (p == 0) ? $urandom_range(0, img_w) + boxes.pad_offsets[15:0]
                         : $urandom_range(0, img_h) + boxes.pad_offsets[31:16];
        v = (coord << 16) | $urandom_range(0, 65535);
      end else if (p < 4) begin
        v = ($urandom_range(0, 400) << 16) | $urandom_range(0, 65535);
        if (pick < 5) v = -v;
      end else if (p < first_score) begin
        if (pick < 5) v = 32'h0;
        else if (pick < 10) v = 32'h8000_0000 | $urandom;
        else if (pick < 15) v = $urandom_range(65536, 32'h7FFF_FFFF);
        else v = $urandom_range(1, 65536);
      end else begin
        // some repeats of the previous score to exercise ties
        if (pick < 15 && last_score != 0) v = last_score;
        else v = 32'($urandom_range(0, 72000)) - 32'd8000;
        last_score = v;
      end
      send_feature(feat(v, fin));
    end
  endtask

  // Main sequence
  initial begin
    logic [31:0] row_vals[$];
    int unsigned items_start, len;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    feat_if.valid = 1'b0;
    feat_if.data  = '0;
    quiet         = 1'b0;
    stall_req     = 1'b0;
    items_sent    = 0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: objectness plus two classes
    apply_setting(1'b1, 7'd2, 17'd0, 24'd65536, 32'h0, {16'd480, 16'd640}, 16'd0, '1);
    // saturated confidence, tied scores
    row_vals = {32'h0140_0000, 32'h00F0_0000, 32'h0064_8000, 32'h0032_4000,
                32'h7FFF_FFFF, 32'h0000_8000, 32'h0000_8000};
    send_values(row_vals, -1);
    // field extremes with one non-finite feature
    row_vals = {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000};
    send_values(row_vals, 3);
    // objectness zero
    row_vals = {32'h0140_0000, 32'h00F0_0000, 32'h0010_0000, 32'h0010_0000,
                32'h0000_0000, 32'h0000_4000, 32'h0000_2000};
    send_values(row_vals, -1);

    // No objectness, one class, padded letterbox
    apply_setting(1'b0, 7'd1, 17'd16384, 24'd65536, 32'h0008_0004, {16'd480, 16'd640},
                  16'd0, '1);
    // negative size: corners cross, box of size zero
    row_vals = {32'h0064_0000, 32'h0064_0000, 32'hFFC0_0000, 32'hFFE0_0000, 32'h0000_C000};
    send_values(row_vals, -1);
    // no positive score
    row_vals = {32'h0064_0000, 32'h0064_0000, 32'h0010_0000, 32'h0010_0000, 32'h8000_0000};
    send_values(row_vals, -1);

    // Output held off while rows keep coming, so the input backs up
    apply_setting(1'b0, 7'd1, 17'd0, 24'd65536, 32'h0, {16'd1000, 16'd1000}, 16'd0, '1);
    quiet     = 1'b1;
    stall_req = 1'b1;
    repeat (40) send_random_row(1'b0);
    wait_for_boxes();
    quiet = 1'b0;

    // Class count lowered mid-row: the row ends at the next feature
    apply_setting(1'b1, 7'd4, 17'd0, 24'd65536, 32'h0, {16'd480, 16'd640}, 16'd0, '1);
    row_vals = {32'h0140_0000, 32'h00F0_0000, 32'h0040_0000, 32'h0020_0000,
                32'h0000_C000, 32'h0000_6000, 32'h0000_9000};
    send_values(row_vals, -1);
    write_reg(CfgClassCount, 64'd1);
    row_vals = {32'h0000_4000};
    send_values(row_vals, -1);

    // Random phases; the first one runs without idling on either side
    items_start = items_sent;
    quiet       = 1'b1;
    while (items_sent - items_start < RandomItems) begin
      random_setting();
      len = boxes.row_length();
      repeat ((len > 20) ? $urandom_range(2, 4) : $urandom_range(8, 30))
        send_random_row($urandom_range(99) < 15);
      quiet = 1'b0;
    end

    wait_for_boxes();
    if (boxes.mismatches == 0 && boxes.expected_boxes.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: detection_row_decoder.f
+incdir+rtl
rtl/drd_pkg.sv
rtl/drd_stream_if.sv
rtl/detection_row_decoder.sv
rtl/drd_checker.sv
test/testbench.sv
